>>> rtl/core/jlu_pkg.sv
// Package with constants, field positions and sequencer states of the jump/load instruction unit.
`default_nettype none

package jlu_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int WORD_W    = 32;
  localparam int OFF_W     = 19;
  localparam int ADDR_IN_W = 12;
  localparam int BYTE_W    = 8;

  localparam logic       OP_EXEC   = 1'b0;
  localparam logic       OP_MEMWR  = 1'b1;
  localparam logic [3:0] OPC_JUMP  = 4'd0;
  localparam logic [3:0] OPC_LOAD  = 4'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OFF,
    S_RD_BASE,
    S_RD_COND,
    S_ADD,
    S_CHECK,
    S_MREAD,
    S_MSHIFT,
    S_RFWR,
    S_MWRITE,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/jlu_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface jlu_in_if
  import jlu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [WORD_W-1:0]    instruction_word;
  logic [ADDR_IN_W-1:0] mem_address;
  logic [BYTE_W-1:0]    mem_byte;

  modport source (output valid, operation, instruction_word, mem_address, mem_byte,
                  input ready);
  modport sink (input valid, operation, instruction_word, mem_address, mem_byte,
                output ready);
endinterface

interface jlu_out_if
  import jlu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] program_counter_out;
  logic              jump_taken;
  logic              reg_written;
  logic [REG_AW-1:0] dest_index;
  logic [WORD_W-1:0] dest_value;
  logic              address_error;

  modport source (output valid, program_counter_out, jump_taken, reg_written, dest_index,
                  dest_value, address_error, input ready);
  modport sink (input valid, program_counter_out, jump_taken, reg_written, dest_index,
                dest_value, address_error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jump_load_instruction_unit.sv
// Top level of the jump/load instruction unit: sequencer, register file, byte memory, adder.
//
//   channel   direction  handshake               payload
//   in_chan   input      valid/ready, sink       operation, instruction_word, mem_address,
//                                                mem_byte
//   out_chan  output     valid/ready, source     program_counter_out, jump_taken, reg_written,
//                                                dest_index, dest_value, address_error
//
// One item is in work at a time. A memory write passes S_MWRITE; a jump reads offset, base
// and condition registers in turn and adds; a load does the same, checks the address and,
// if size and address are good, reads each byte in an S_MREAD/S_MSHIFT pair before S_RFWR;
// other opcodes go to S_FINISH at once. Register file and byte memory have one read port each.
// Reset clears the registers, the program counter and the sequencer; memory is not cleared.
// A waiting result does not stop the next item from being accepted and worked on; that
// item's result then waits until the output register is free.
`default_nettype none

module jump_load_instruction_unit
  import jlu_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  jlu_in_if.sink    in_chan,
  jlu_out_if.source out_chan
);

  state_t state_r, state_nxt;

  logic                 op_r;
  logic [WORD_W-1:0]    instr_r;
  logic [ADDR_IN_W-1:0] maddr_r;
  logic [BYTE_W-1:0]    mbyte_r;

  logic [WORD_W-1:0] regs_r [NUM_REGS];
  logic [WORD_W-1:0] rf_rdata_r;
  logic [REG_AW-1:0] rf_raddr;
  logic              rf_we;

  logic [BYTE_W-1:0] byte_mem [MEM_BYTES];
  logic [BYTE_W-1:0] mem_rdata_r;
  logic [MEM_AW-1:0] mem_ptr_r;
  logic              mem_we;
  logic              mem_re;

  logic [WORD_W-1:0] off_r;
  logic [WORD_W-1:0] base_r;
  logic [WORD_W-1:0] addr_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] pc_r;
  logic [WORD_W-1:0] sum;
  logic [1:0]        left_r;
  logic              jump_r;
  logic              written_r;
  logic              err_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_pc_r;
  logic              out_jump_r;
  logic              out_written_r;
  logic [REG_AW-1:0] out_dest_r;
  logic [WORD_W-1:0] out_value_r;
  logic              out_err_r;

  logic              in_ready;
  logic              accept;
  logic              res_load;

  logic              is_jump;
  logic              imm_sel;
  logic [OFF_W-1:0]  off_field;
  logic [1:0]        ld_size;
  logic [REG_AW-1:0] ld_dest;
  logic [2:0]        ld_bytes;
  logic [MEM_AW:0]   ld_end;
  logic              ld_bad;
  logic              jump_go;
  logic [3:0]        in_opcode;

  assign is_jump   = (instr_r[3:0] == OPC_JUMP);
  assign imm_sel   = is_jump ? instr_r[4] : instr_r[6];
  assign off_field = is_jump ? instr_r[30:12] : instr_r[31:13];
  assign ld_size   = instr_r[5:4];
  assign ld_dest   = instr_r[9:7];
  assign in_opcode = in_chan.instruction_word[3:0];

  always_comb begin
    case (ld_size)
      SIZE_BYTE: ld_bytes = 3'd1;
      SIZE_HALF: ld_bytes = 3'd2;
      SIZE_WORD: ld_bytes = 3'd4;
      default:   ld_bytes = 3'd0;
    endcase
  end

  assign sum     = base_r + off_r;
  assign ld_end  = {1'b0, addr_r[MEM_AW-1:0]} + (MEM_AW+1)'(ld_bytes);
  assign ld_bad  = (addr_r >= WORD_W'(MEM_BYTES)) || (ld_end > (MEM_AW+1)'(MEM_BYTES));
  assign jump_go = !(instr_r[8] && (rf_rdata_r == '0));

  assign accept   = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.operation == OP_MEMWR) begin
            state_nxt = S_MWRITE;
          end else if (in_opcode == OPC_JUMP || in_opcode == OPC_LOAD) begin
            state_nxt = S_RD_OFF;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_RD_OFF:  state_nxt = S_RD_BASE;
      S_RD_BASE: state_nxt = S_RD_COND;
      S_RD_COND: state_nxt = S_ADD;
      S_ADD:     state_nxt = is_jump ? S_FINISH : S_CHECK;
      S_CHECK:   state_nxt = (ld_size == SIZE_NONE || ld_bad) ? S_FINISH : S_MREAD;
      S_MREAD:   state_nxt = S_MSHIFT;
      S_MSHIFT:  state_nxt = (left_r == 2'd0) ? S_RFWR : S_MREAD;
      S_RFWR:    state_nxt = S_FINISH;
      S_MWRITE:  state_nxt = S_FINISH;
      S_FINISH:  state_nxt = res_load ? S_IDLE : S_FINISH;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rf_raddr = '0;
    rf_we    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_load = 1'b0;
    unique case (state_r)
      S_IDLE:    in_ready = 1'b1;
      S_RD_OFF:  rf_raddr = off_field[REG_AW-1:0];
      S_RD_BASE: rf_raddr = is_jump ? instr_r[7:5] : instr_r[12:10];
      S_RD_COND: rf_raddr = instr_r[11:9];
      S_MREAD:   mem_re = 1'b1;
      S_RFWR:    rf_we = 1'b1;
      S_MWRITE:  mem_we = (WORD_W'(maddr_r) < WORD_W'(MEM_BYTES));
      S_FINISH:  res_load = !out_valid_r || out_chan.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[maddr_r[MEM_AW-1:0]] <= mbyte_r;
    end
    if (mem_re) begin
      mem_rdata_r <= byte_mem[mem_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      jump_r      <= 1'b0;
      written_r   <= 1'b0;
      err_r       <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        jump_r    <= 1'b0;
        written_r <= 1'b0;
        err_r     <= 1'b0;
      end
      if (state_r == S_ADD && is_jump && jump_go) begin
        pc_r   <= sum;
        jump_r <= 1'b1;
      end
      if (state_r == S_CHECK && ld_size != SIZE_NONE && ld_bad) begin
        err_r <= 1'b1;
      end
      if (rf_we) begin
        regs_r[ld_dest] <= acc_r;
        written_r       <= 1'b1;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rf_rdata_r <= regs_r[rf_raddr];
    if (accept) begin
      op_r    <= in_chan.operation;
      instr_r <= in_chan.instruction_word;
      maddr_r <= in_chan.mem_address;
      mbyte_r <= in_chan.mem_byte;
      acc_r   <= '0;
    end
    if (state_r == S_RD_BASE) begin
      off_r <= imm_sel ? WORD_W'(off_field) : rf_rdata_r;
    end
    if (state_r == S_RD_COND) begin
      base_r <= rf_rdata_r;
    end
    if (state_r == S_ADD) begin
      addr_r <= sum;
    end
    if (state_r == S_CHECK) begin
      mem_ptr_r <= addr_r[MEM_AW-1:0];
      left_r    <= 2'(ld_bytes - 3'd1);
    end
    if (state_r == S_MREAD) begin
      mem_ptr_r <= mem_ptr_r + 1'b1;
    end
    if (state_r == S_MSHIFT) begin
      acc_r <= {acc_r[WORD_W-BYTE_W-1:0], mem_rdata_r};
      if (left_r != 2'd0) begin
        left_r <= left_r - 2'd1;
      end
    end
    if (res_load) begin
      out_pc_r      <= pc_r;
      out_jump_r    <= jump_r && (op_r == OP_EXEC);
      out_written_r <= written_r;
      out_dest_r    <= written_r ? ld_dest : '0;
      out_value_r   <= written_r ? acc_r : '0;
      out_err_r     <= err_r;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.program_counter_out = out_pc_r;
  assign out_chan.jump_taken          = out_jump_r;
  assign out_chan.reg_written         = out_written_r;
  assign out_chan.dest_index          = out_dest_r;
  assign out_chan.dest_value          = out_value_r;
  assign out_chan.address_error       = out_err_r;

endmodule

`default_nettype wire

>>> bench/jlu_outcome_checker.sv
// Checker that predicts each item's outcome from the input channel and compares results.
`timescale 1ns / 100ps

module jlu_outcome_checker
  import jlu_pkg::*;
(
  input  wire                              clk,
  input  wire                              rst_n,
  jlu_in_if                                in_mon,
  jlu_out_if                               out_mon,
  output int                               mismatches,
  output int                               pending,
  output logic [NUM_REGS-1:0][WORD_W-1:0]  reg_state
);

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic              jump;
    logic              written;
    logic [REG_AW-1:0] dest;
    logic [WORD_W-1:0] value;
    logic              error;
  } outcome_t;

  outcome_t                        outcome_q[$];
  outcome_t                        got;
  outcome_t                        want;
  logic [NUM_REGS-1:0][WORD_W-1:0] reg_image;
  logic [WORD_W-1:0]               pc_image;
  logic [BYTE_W-1:0]               mem_image [MEM_BYTES];

  assign reg_state = reg_image;

  function automatic outcome_t execute_item(logic op, logic [WORD_W-1:0] w,
                                            logic [ADDR_IN_W-1:0] maddr,
                                            logic [BYTE_W-1:0] mbyte);
    outcome_t          r;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] v;
    int                n;
    r = '0;
    if (op == OP_MEMWR) begin
      if (maddr < MEM_BYTES) mem_image[maddr] = mbyte;
    end else if (w[3:0] == OPC_JUMP) begin
      off = w[4] ? {13'b0, w[30:12]} : reg_image[w[14:12]];
      if (!(w[8] && reg_image[w[11:9]] == '0)) begin
        pc_image = reg_image[w[7:5]] + off;
        r.jump = 1'b1;
      end
    end else if (w[3:0] == OPC_LOAD) begin
      off = w[6] ? {13'b0, w[31:13]} : reg_image[w[15:13]];
      addr = reg_image[w[12:10]] + off;
      if (w[5:4] != SIZE_NONE) begin
        n = (w[5:4] == SIZE_BYTE) ? 1 : (w[5:4] == SIZE_HALF) ? 2 : 4;
        if (addr >= MEM_BYTES || n > MEM_BYTES - addr) begin
          r.error = 1'b1;
        end else begin
          v = '0;
          for (int i = 0; i < n; i++) v = (v << 8) | mem_image[addr + i];
          reg_image[w[9:7]] = v;
          r.written = 1'b1;
          r.dest = w[9:7];
          r.value = v;
        end
      end
    end
    r.pc = pc_image;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_image = '0;
      pc_image = '0;
      outcome_q.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.program_counter_out, out_mon.jump_taken, out_mon.reg_written,
                out_mon.dest_index, out_mon.dest_value, out_mon.address_error};
        if (outcome_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing outstanding: pc=%h", $realtime, got.pc);
          end
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: expected pc=%h jump=%b wr=%b idx=%0d val=%h err=%b", $realtime,
                       want.pc, want.jump, want.written, want.dest, want.value, want.error);
              $display("%0t: actual   pc=%h jump=%b wr=%b idx=%0d val=%h err=%b", $realtime,
                       got.pc, got.jump, got.written, got.dest, got.value, got.error);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        outcome_q.push_back(execute_item(in_mon.operation, in_mon.instruction_word,
                                         in_mon.mem_address, in_mon.mem_byte));
      end
    end
    pending = outcome_q.size();
  end

endmodule

>>> bench/tb.sv
// Top of the testbench: clock, reset, item stimulus, result back-pressure and the verdict.
`timescale 1ns / 100ps

module tb
  import jlu_pkg::*;
();

  logic                            clk;
  logic                            rst_n;
  int                              mismatches;
  int                              pending;
  logic [NUM_REGS-1:0][WORD_W-1:0] reg_state;
  bit                              mem_written [MEM_BYTES];
  logic [WORD_W-1:0]               written_list[$];
  bit                              steady;

  jlu_in_if  in_chan ();
  jlu_out_if out_chan ();

  jump_load_instruction_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  jlu_outcome_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches (mismatches),
    .pending    (pending),
    .reg_state  (reg_state)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [WORD_W-1:0] load_insn(logic [1:0] size, logic imm, logic [2:0] dest,
                                                  logic [2:0] base, logic [OFF_W-1:0] off);
    return {off, base, dest, imm, size, OPC_LOAD};
  endfunction

  function automatic logic [WORD_W-1:0] jump_insn(logic imm, logic [2:0] base, logic cond,
                                                  logic [2:0] creg, logic [OFF_W-1:0] off);
    return {1'b1, off, creg, cond, base, imm, OPC_JUMP};
  endfunction

  function automatic bit fits(logic [WORD_W-1:0] addr, int n);
    return addr < MEM_BYTES && n <= MEM_BYTES - addr;
  endfunction

  function automatic bit readable(logic [WORD_W-1:0] addr, int n);
    if (!fits(addr, n)) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!mem_written[addr + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Builds a load of written bytes or one that falls outside memory, else a SIZE_NONE load.
  function automatic logic [WORD_W-1:0] pick_load();
    logic [1:0]        size;
    logic              imm;
    logic [2:0]        dest;
    logic [2:0]        base;
    logic [OFF_W-1:0]  field;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] off;
    int                n;
    bit                want_error;
    bit                ok;
    want_error = ($urandom_range(99) < 15);
    for (int t = 0; t < 48; t++) begin
      size = $urandom_range(1) ? SIZE_BYTE : 2'($urandom_range(1, 2));
      n = (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
      imm = 1'($urandom);
      dest = 3'($urandom);
      base = 3'($urandom);
      field = OFF_W'($urandom);
      if (imm && !want_error) begin
        addr = written_list[$urandom_range(written_list.size() - 1)];
        off = addr - reg_state[base];
        field = off[OFF_W-1:0];
        ok = (off < 32'h0008_0000) && readable(addr, n);
      end else begin
        off = imm ? {13'b0, field} : reg_state[field[2:0]];
        addr = reg_state[base] + off;
        ok = want_error ? !fits(addr, n) : readable(addr, n);
      end
      if (ok) return load_insn(size, imm, dest, base, field);
    end
    return load_insn(SIZE_NONE, 1'($urandom), 3'($urandom), 3'($urandom), OFF_W'($urandom));
  endfunction

  function automatic logic [BYTE_W-1:0] mem_value();
    int roll;
    roll = $urandom_range(3);
    if (roll < 2) return '0;
    if (roll == 2) return BYTE_W'($urandom_range(15));
    return BYTE_W'($urandom);
  endfunction

  task automatic idle_gap(bit bubble);
    if (bubble || (!steady && $urandom_range(99) < 23)) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while (!steady && $urandom_range(99) < 23) @(posedge clk);
    end
  endtask

  task automatic send_item(logic op, logic [WORD_W-1:0] word, logic [ADDR_IN_W-1:0] addr,
                           logic [BYTE_W-1:0] data);
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.instruction_word <= word;
    in_chan.mem_address <= addr;
    in_chan.mem_byte <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (op == OP_MEMWR && addr < MEM_BYTES && !mem_written[addr]) begin
      mem_written[addr] = 1'b1;
      written_list.push_back(addr);
    end
  endtask

  task automatic send_exec(logic [WORD_W-1:0] word);
    idle_gap(1'b0);
    send_item(OP_EXEC, word, ADDR_IN_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic send_mem(logic [ADDR_IN_W-1:0] addr, logic [BYTE_W-1:0] data);
    idle_gap(1'b0);
    send_item(OP_MEMWR, $urandom, addr, data);
  endtask

  initial begin
    int               cyc;
    int               hold;
    cyc = 0;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 9000) hold = 400;
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (cyc >= 6000 && cyc < 7500) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    int               sent;
    int               roll;
    int               run_len;
    logic [ADDR_IN_W-1:0] start;
    steady = 1'b0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.operation <= OP_EXEC;
    in_chan.instruction_word <= '0;
    in_chan.mem_address <= '0;
    in_chan.mem_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_mem(12'd0, 8'h80);
    send_mem(12'd1, 8'h01);
    send_mem(12'd2, 8'hFF);
    send_mem(12'd3, 8'h7F);
    send_mem(12'd4, 8'h10);
    send_mem(12'd5, 8'h04);
    send_mem(12'd4093, 8'hA5);
    send_mem(12'd4094, 8'h5A);
    send_mem(12'd4095, 8'hC3);
    idle_gap(1'b0);
    send_item(OP_EXEC, 32'hFFFF_FFFF, 12'hFFF, 8'hFF);
    send_exec(32'h0000_0002);
    send_exec(jump_insn(1'b1, 3'd0, 1'b0, 3'd0, 19'h7FFFF));
    send_exec(jump_insn(1'b1, 3'd0, 1'b1, 3'd1, 19'h00123));
    send_exec(load_insn(SIZE_BYTE, 1'b1, 3'd1, 3'd0, 19'd0));
    send_exec(load_insn(SIZE_HALF, 1'b1, 3'd2, 3'd0, 19'd1));
    send_exec(load_insn(SIZE_WORD, 1'b1, 3'd3, 3'd0, 19'd2));
    send_exec(load_insn(SIZE_WORD, 1'b1, 3'd4, 3'd0, 19'd4093));
    send_exec(load_insn(SIZE_HALF, 1'b1, 3'd4, 3'd0, 19'd4094));
    send_exec(load_insn(SIZE_BYTE, 1'b1, 3'd5, 3'd0, 19'd4095));
    send_exec(load_insn(SIZE_BYTE, 1'b1, 3'd6, 3'd0, 19'd4096));
    send_exec(load_insn(SIZE_WORD, 1'b1, 3'd7, 3'd0, 19'h7FFFF));
    send_exec(load_insn(SIZE_NONE, 1'b1, 3'd7, 3'd0, 19'd0));
    send_exec(load_insn(SIZE_BYTE, 1'b0, 3'd6, 3'd0, 19'h7FFF8));
    send_exec(load_insn(SIZE_BYTE, 1'b1, 3'd7, 3'd3, 19'd0));
    send_exec(jump_insn(1'b0, 3'd1, 1'b0, 3'd0, 19'h7FFFA));
    send_exec(jump_insn(1'b0, 3'd3, 1'b1, 3'd3, 19'h00003));
    send_exec(jump_insn(1'b1, 3'd2, 1'b1, 3'd7, 19'h55555));

    sent = 0;
    while (sent < 1400) begin
      steady = (sent >= 600 && sent < 800);
      roll = $urandom_range(99);
      if (roll < 30) begin
        run_len = $urandom_range(1, 4);
        start = $urandom_range(1) ? ADDR_IN_W'($urandom_range(255)) : ADDR_IN_W'($urandom);
        for (int k = 0; k < run_len; k++) begin
          send_mem(start + ADDR_IN_W'(k), mem_value());
          sent++;
        end
      end else if (roll < 60) begin
        // The gap lets the predicted registers settle before the address is planned.
        idle_gap(1'b1);
        send_item(OP_EXEC, pick_load(), ADDR_IN_W'($urandom), BYTE_W'($urandom));
        sent++;
      end else if (roll < 85) begin
        send_exec({$urandom} & ~32'hF | {28'b0, OPC_JUMP});
        sent++;
      end else begin
        send_exec({$urandom} & ~32'hF | 32'($urandom_range(2, 15)));
        sent++;
      end
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
